FILE: rtl/ocf_pkg.sv
// Shared types, frame constants and the CRC-16 byte step for the object request framer.
package ocf_pkg;

   localparam logic [7:0]  FRAME_DLE = 8'h90;
   localparam logic [7:0]  FRAME_STX = 8'h02;
   localparam logic [7:0]  OP_WRITE  = 8'h68;
   localparam logic [7:0]  OP_READ   = 8'h60;
   localparam logic [7:0]  LEN_WRITE = 8'h04;
   localparam logic [7:0]  LEN_READ  = 8'h02;
   localparam logic [7:0]  SUBINDEX  = 8'h00;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_INIT  = 16'h0000;

   // Frame position of the CRC low byte
   localparam logic [3:0]  CRC_POS_WRITE = 4'd12;
   localparam logic [3:0]  CRC_POS_READ  = 4'd8;

   typedef struct packed {
      logic        action;
      logic [15:0] object_index;
      logic [31:0] object_value;
   } req_type;

   typedef struct packed {
      logic take;
      logic busy;
   } frame_stat_type;

   // Shift one byte into the CRC, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        carry;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         carry = c[15];
         c = {c[14:0], data[i]};
         if (carry) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/ocf_req_buf.sv
// Input register holding one request until the frame sequencer takes it.
module ocf_req_buf (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ocf_pkg::req_type req_in,
   input  logic            take,
   output logic            buf_valid,
   output ocf_pkg::req_type buf_req
);
   import ocf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = (valid_ff && !take) || accept;
   assign buf_valid = valid_ff;
   assign buf_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

endmodule

FILE: rtl/ocf_frame.sv
// Frame sequencer: emits one frame byte per cycle while rsp is not stalled and folds the payload into the CRC.
module ocf_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   buf_valid,
   input  ocf_pkg::req_type        buf_req,
   input  logic [7:0]             node_id,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_byte,
   output ocf_pkg::frame_stat_type stat
);
   import ocf_pkg::*;

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   req_type     req_ff, req_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic        advance;
   logic        take;
   logic        emit;
   logic [3:0]  crc_pos;
   logic [7:0]  opcode;
   logic [7:0]  len;
   logic [7:0]  val_byte;
   logic [7:0]  cur_byte;
   logic [7:0]  crc_feed;
   logic        is_last;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign take    = advance && !busy_ff && buf_valid;
   assign emit    = advance && busy_ff;
   assign crc_pos = req_ff.action ? CRC_POS_WRITE : CRC_POS_READ;
   assign opcode  = req_ff.action ? OP_WRITE : OP_READ;
   assign len     = req_ff.action ? LEN_WRITE : LEN_READ;
   assign is_last = (cnt_ff == crc_pos + 4'd1);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    val_byte = req_ff.object_value[7:0];
         2'd1:    val_byte = req_ff.object_value[15:8];
         2'd2:    val_byte = req_ff.object_value[23:16];
         default: val_byte = req_ff.object_value[31:24];
      endcase
   end

   always_comb begin
      case (cnt_ff)
         4'd1:    cur_byte = FRAME_STX;
         4'd2:    cur_byte = opcode;
         4'd3:    cur_byte = len;
         4'd4:    cur_byte = node_id;
         4'd5:    cur_byte = req_ff.object_index[7:0];
         4'd6:    cur_byte = req_ff.object_index[15:8];
         4'd7:    cur_byte = SUBINDEX;
         default: begin
            if (cnt_ff == crc_pos) begin
               cur_byte = crc_ff[7:0];
            end else if (is_last) begin
               cur_byte = crc_ff[15:8];
            end else begin
               cur_byte = val_byte;
            end
         end
      endcase
   end

   // Payload words go in high byte first, so each byte pair is fed swapped
   always_comb begin
      case (cnt_ff)
         4'd1:    crc_feed = opcode;
         4'd2:    crc_feed = req_ff.object_index[7:0];
         4'd3:    crc_feed = node_id;
         4'd4:    crc_feed = SUBINDEX;
         4'd5:    crc_feed = req_ff.object_index[15:8];
         4'd6:    crc_feed = req_ff.action ? req_ff.object_value[15:8] : 8'h00;
         4'd7:    crc_feed = req_ff.action ? req_ff.object_value[7:0] : 8'h00;
         4'd8:    crc_feed = req_ff.object_value[31:24];
         4'd9:    crc_feed = req_ff.object_value[23:16];
         default: crc_feed = 8'h00;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      crc_in       = crc_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      if (take) begin
         // The first CRC step is the length byte of the new request
         req_in       = buf_req;
         busy_in      = 1'b1;
         cnt_in       = 4'd1;
         crc_in       = crc_byte(CRC_INIT, buf_req.action ? LEN_WRITE : LEN_READ);
         byte_in      = FRAME_DLE;
         last_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (emit) begin
         byte_in      = cur_byte;
         last_in      = is_last;
         busy_in      = !is_last;
         cnt_in       = cnt_ff + 4'd1;
         rsp_valid_in = 1'b1;
         if (cnt_ff < crc_pos) begin
            crc_in = crc_byte(crc_ff, crc_feed);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      crc_ff  <= crc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;
   assign stat.take      = take;
   assign stat.busy      = busy_ff;

endmodule

FILE: rtl/object_request_framer_crc16.sv
// Top level of the object request framer: node id register, input register and frame sequencer.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_action, req_object_index, req_object_value
//   rsp      out        rsp_valid/rsp_stall rsp_frame_byte, rsp_last_byte
//   csr      in         csr_valid/csr_ready csr_node_id
//
// A write request yields 14 frame bytes and a read request 10, one byte per cycle while rsp
// is not stalled; frames follow with no gap.
// The CRC is folded in one payload byte per emitted frame byte, up to the CRC low byte.
// Reset clears the handshake state and sets node id to 1.
// A stalled rsp holds the sequencer; one further request waits in the input register.
module object_request_framer_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_object_index,
   input  logic [31:0] req_object_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_node_id
);
   import ocf_pkg::*;

   logic [7:0]     node_id_ff;
   logic [7:0]     node_id_in;
   req_type        req_in;
   req_type        buf_req;
   logic           buf_valid;
   frame_stat_type stat;

   assign csr_ready  = 1'b1;
   assign node_id_in = (csr_valid && csr_ready) ? csr_node_id : node_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= 8'd1;
      end else begin
         node_id_ff <= node_id_in;
      end
   end

   assign req_in.action       = req_action;
   assign req_in.object_index = req_object_index;
   assign req_in.object_value = req_object_value;

   ocf_req_buf u_req_buf (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in    (req_in),
      .take      (stat.take),
      .buf_valid (buf_valid),
      .buf_req   (buf_req)
   );

   ocf_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .buf_valid      (buf_valid),
      .buf_req        (buf_req),
      .node_id        (node_id_ff),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte),
      .stat           (stat)
   );

   // An empty input register never stalls the request side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !buf_valid |-> !req_stall)
      else $error("req stalled with empty input register");

   // A frame ends on its flagged byte
   a_busy_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(stat.busy) |-> (rsp_valid && rsp_last_byte))
      else $error("sequencer went idle without a flagged last byte");

   // Right after a frame closes, the next byte shown opens a new frame
   a_frame_starts_dle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_byte) |=> (!rsp_valid || rsp_frame_byte == FRAME_DLE))
      else $error("frame does not open with DLE");

endmodule

FILE: tb/sv/object_request_framer_crc16_tb.sv
// Self-checking testbench for the object request framer with CRC-16 trailer.
`timescale 1ns / 100ps

module object_request_framer_crc16_tb;
   import ocf_pkg::*;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [15:0] req_object_index = 16'h0000;
   logic [31:0] req_object_value = 32'h0000_0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_node_id = 8'h00;

   req_type       pending_reqs[$];
   frame_out_type frame_bytes_due[$];
   logic [7:0]    node_id_model = 8'd1;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   mismatch_count = 0;

   object_request_framer_crc16 i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_object_index (req_object_index),
      .req_object_value (req_object_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_node_id      (csr_node_id)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shift one 16-bit word into the CRC, MSB first
   function automatic logic [15:0] crc_fold_word(input logic [15:0] crc, input logic [15:0] word);
      logic carry;
      for (int i = 15; i >= 0; i--) begin
         carry = crc[15];
         crc = {crc[14:0], word[i]};
         if (carry) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   // Queue the bytes of the frame that one accepted request must produce
   function automatic void build_request_frame(input req_type r);
      logic [7:0]    f[14];
      int            n;
      logic [15:0]   crc;
      frame_out_type o;
      f[0] = FRAME_DLE;
      f[1] = FRAME_STX;
      f[2] = r.action ? OP_WRITE : OP_READ;
      f[3] = r.action ? LEN_WRITE : LEN_READ;
      f[4] = node_id_model;
      f[5] = r.object_index[7:0];
      f[6] = r.object_index[15:8];
      f[7] = SUBINDEX;
      n = 8;
      if (r.action) begin
         f[8]  = r.object_value[7:0];
         f[9]  = r.object_value[15:8];
         f[10] = r.object_value[23:16];
         f[11] = r.object_value[31:24];
         n = 12;
      end
      // Payload runs from the opcode, as little-endian words, then one zero word
      crc = CRC_INIT;
      for (int i = 2; i + 1 < n; i += 2) begin
         crc = crc_fold_word(crc, {f[i + 1], f[i]});
      end
      crc = crc_fold_word(crc, 16'h0000);
      f[n] = crc[7:0];
      f[n + 1] = crc[15:8];
      n = n + 2;
      for (int k = 0; k < n; k++) begin
         o.frame_byte = f[k];
         o.last_byte = (k == n - 1);
         frame_bytes_due.push_back(o);
      end
   endfunction

   // Request driver: hold a stalled request, otherwise advance or idle
   always @(posedge clock) begin
      req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            build_request_frame('{req_action, req_object_index, req_object_value});
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_action <= nxt.action;
               req_object_index <= nxt.object_index;
               req_object_value <= nxt.object_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Frame byte monitor and receiver stall
   always @(posedge clock) begin
      frame_out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected frame byte %h, last %b", rsp_frame_byte, rsp_last_byte);
               mismatch_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== want.frame_byte) begin
                  $error("frame_byte: expected %h, actual %h", want.frame_byte, rsp_frame_byte);
                  mismatch_count++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $error("last_byte: expected %b, actual %b", want.last_byte, rsp_last_byte);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic push_req(input logic action, input logic [15:0] index, input logic [31:0] value);
      pending_reqs.push_back('{action, index, value});
   endtask

   // Wait until every request has gone in and every frame byte has come out
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || frame_bytes_due.size() != 0);
   endtask

   task automatic write_node_id(input logic [7:0] id);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_node_id <= id;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      node_id_model = id;
   endtask

   task automatic push_random_reqs(input int count);
      logic [15:0] index;
      logic [31:0] value;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: index = 16'h0000;
            1: index = 16'hFFFF;
            default: index = 16'($urandom);
         endcase
         case ($urandom_range(9))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         push_req(1'($urandom_range(1)), index, value);
      end
   endtask

   initial begin
      logic [7:0]  node_ids[4];
      int unsigned idle_pcts[4];
      int unsigned stall_pcts[4];
      node_ids = '{8'h00, 8'hFF, FRAME_DLE, 8'h00};
      node_ids[3] = 8'($urandom);
      idle_pcts = '{0, 82, 0, 7};
      stall_pcts = '{0, 0, 82, 7};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with the reset node id
      push_req(1'b0, 16'h0000, 32'h0000_0000);
      push_req(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(1'b1, 16'h0000, 32'h0000_0000);
      push_req(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(1'b1, 16'h5555, 32'hAAAA_AAAA);
      push_req(1'b1, 16'hAAAA, 32'h5555_5555);
      push_req(1'b0, 16'h5555, 32'h1234_5678);
      push_req(1'b0, 16'hAAAA, 32'h0000_0000);
      // DLE bytes inside the frame go out unstuffed
      push_req(1'b1, 16'h9090, 32'h9090_9090);
      push_req(1'b0, 16'h9002, 32'h0290_0290);
      push_req(1'b1, 16'h6040, 32'h0000_0001);
      push_req(1'b1, 16'h607A, 32'h8000_0000);
      // Read requests whose value must not reach the frame, with one write among them
      push_req(1'b0, 16'h6064, 32'hDEAD_BEEF);
      push_req(1'b0, 16'h6064, 32'h0000_0000);
      push_req(1'b1, 16'h0001, 32'h0000_00FF);
      push_req(1'b0, 16'h8000, 32'hFFFF_FFFF);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_node_id(node_ids[p]);
         send_idle_pct = idle_pcts[p];
         recv_stall_pct = stall_pcts[p];
         push_random_reqs(60);
         // Hold the sender until the block has emptied
         wait_drained();
         push_random_reqs(49);
         wait_drained();
      end

      // Back to the reset node id with a few more requests
      write_node_id(8'd1);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      push_random_reqs(8);
      wait_drained();

      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
